### design/nfarm_pkg.sv
// ----------------------------------------------------------------------------
// nfarm_pkg
// Shared constants and types for the NFA regex matcher: state-index widths,
// request function codes, configuration indexes, table entry and worklist control.
// ----------------------------------------------------------------------------
package nfarm_pkg;

    // NFA size
    localparam int NUM_STATES = 64;
    localparam int IDX_W      = $clog2(NUM_STATES);
    localparam int PTR_W      = IDX_W + 1;

    // request function codes (carried on tuser)
    localparam logic [1:0] FN_WRITE = 2'd0;
    localparam logic [1:0] FN_START = 2'd1;
    localparam logic [1:0] FN_CHAR  = 2'd2;

    // configuration register indexes
    localparam logic CFG_START  = 1'b0;
    localparam logic CFG_ACCEPT = 1'b1;

    // one transition table entry, 29 bits
    typedef struct packed {
        logic [IDX_W-1:0] eps_second;
        logic [IDX_W-1:0] eps_first;
        logic [1:0]       eps_count;
        logic [IDX_W-1:0] label_target;
        logic             has_label;
        logic [7:0]       label;
    } t_entry;

    // worklist control from the sequencer
    typedef struct packed {
        logic             clear;
        logic             push;
        logic [IDX_W-1:0] push_idx;
        logic             pop;
    } t_wl_ctrl;

endpackage

### design/nfa_regex_matcher_top.sv
// Write request: stored in the table, no result.
// Start request: epsilon closure of the start state, then result.
// Char request: label scan over the table memory, then the epsilon closure
// of the states reached, then result; one request at a time.
// Reset clears the active set, the configuration and the handshake state;
// the transition table holds nothing valid until written.
// ----------------------------------------------------------------------------
// nfa_regex_matcher_top
// Thompson NFA simulation: sequencer over the transition table memory and
// the closure work queue, holding the active and visited sets in registers.
// ----------------------------------------------------------------------------
module nfa_regex_matcher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [5:0] entry_index, [13:6] entry_label, [14] entry_has_label,
    // [20:15] entry_label_target, [22:21] entry_eps_count, [28:23] eps_first,
    // [34:29] eps_second, [42:35] in_char, [47:43] zero
    input  logic [47:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,   // [1:0] func
    // result channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [0] matched, [1] dead, [7:2] zero
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [5:0]  i_cfg_wdata
);

    localparam int IW = nfarm_pkg::IDX_W;
    localparam int NS = nfarm_pkg::NUM_STATES;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SCAN   = 8'b0000_0010,
        ST_Q_RD   = 8'b0000_0100,
        ST_Q_WAIT = 8'b0000_1000,
        ST_EPS0   = 8'b0001_0000,
        ST_EPS1   = 8'b0010_0000,
        ST_REPORT = 8'b0100_0000
    } t_state;

    t_state              r_state, n_state;
    logic [IW-1:0]       r_cfg_start, n_cfg_start;
    logic [IW-1:0]       r_cfg_accept, n_cfg_accept;
    logic [NS-1:0]       r_active, n_active;
    logic [NS-1:0]       r_visited, n_visited;
    logic [7:0]          r_char, n_char;
    logic [IW:0]         r_scan, n_scan;
    logic [IW-1:0]       r_eval_idx, n_eval_idx;
    logic                r_eval_vld, n_eval_vld;
    logic                r_m_valid, n_m_valid;
    logic                r_matched, n_matched;
    logic                r_dead, n_dead;

    logic                s_accept;
    nfarm_pkg::t_entry   s_wr_entry;
    logic                s_tbl_wr;
    logic                s_tbl_rd;
    logic [IW-1:0]       s_tbl_addr;
    nfarm_pkg::t_entry   s_tbl_q;
    nfarm_pkg::t_wl_ctrl s_wl;
    logic                s_wl_empty;
    logic [IW-1:0]       s_wl_idx;

    // request unpacking
    assign s_wr_entry.label        = i_s_tdata[13:6];
    assign s_wr_entry.has_label    = i_s_tdata[14];
    assign s_wr_entry.label_target = i_s_tdata[20:15];
    assign s_wr_entry.eps_count    = i_s_tdata[22:21];
    assign s_wr_entry.eps_first    = i_s_tdata[28:23];
    assign s_wr_entry.eps_second   = i_s_tdata[34:29];

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid & o_s_tready;

    nfarm_table u_table (
        .i_clk      (i_clk),
        .i_wr_en    (s_tbl_wr),
        .i_wr_addr  (i_s_tdata[5:0]),
        .i_wr_entry (s_wr_entry),
        .i_rd_en    (s_tbl_rd),
        .i_rd_addr  (s_tbl_addr),
        .o_rd_entry (s_tbl_q)
    );

    nfarm_worklist u_worklist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (s_wl),
        .o_empty   (s_wl_empty),
        .o_pop_idx (s_wl_idx)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cfg_start  = r_cfg_start;
        n_cfg_accept = r_cfg_accept;
        n_active     = r_active;
        n_visited    = r_visited;
        n_char       = r_char;
        n_scan       = r_scan;
        n_eval_idx   = r_eval_idx;
        n_eval_vld   = r_eval_vld;
        n_m_valid    = r_m_valid;
        n_matched    = r_matched;
        n_dead       = r_dead;
        s_tbl_wr     = 1'b0;
        s_tbl_rd     = 1'b0;
        s_tbl_addr   = r_scan[IW-1:0];
        s_wl         = '0;

        // configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                nfarm_pkg::CFG_START:  n_cfg_start  = i_cfg_wdata;
                nfarm_pkg::CFG_ACCEPT: n_cfg_accept = i_cfg_wdata;
                default: ;
            endcase
        end

        // result taken downstream
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (i_s_tuser)
                        nfarm_pkg::FN_WRITE: begin
                            s_tbl_wr = 1'b1;
                        end
                        nfarm_pkg::FN_START: begin
                            n_visited              = '0;
                            n_visited[r_cfg_start] = 1'b1;
                            s_wl.clear             = 1'b1;
                            s_wl.push              = 1'b1;
                            s_wl.push_idx          = r_cfg_start;
                            n_state                = ST_Q_RD;
                        end
                        nfarm_pkg::FN_CHAR: begin
                            n_visited  = '0;
                            s_wl.clear = 1'b1;
                            n_char     = i_s_tdata[42:35];
                            n_scan     = '0;
                            n_eval_vld = 1'b0;
                            n_state    = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // read entry r_scan, test the previously read entry from the registered read data
                s_tbl_rd   = ~r_scan[IW];
                n_scan     = r_scan + {{IW{1'b0}}, 1'b1};
                n_eval_idx = r_scan[IW-1:0];
                n_eval_vld = ~r_scan[IW];
                if (r_eval_vld && r_active[r_eval_idx] && s_tbl_q.has_label &&
                    (s_tbl_q.label == r_char) && !r_visited[s_tbl_q.label_target]) begin
                    n_visited[s_tbl_q.label_target] = 1'b1;
                    s_wl.push                       = 1'b1;
                    s_wl.push_idx                   = s_tbl_q.label_target;
                end
                if (r_scan[IW]) begin
                    n_state = ST_Q_RD;
                end
            end
            ST_Q_RD: begin
                if (s_wl_empty) begin
                    n_state = ST_REPORT;
                end else begin
                    s_wl.pop = 1'b1;
                    n_state  = ST_Q_WAIT;
                end
            end
            ST_Q_WAIT: begin
                s_tbl_rd   = 1'b1;
                s_tbl_addr = s_wl_idx;
                n_state    = ST_EPS0;
            end
            ST_EPS0: begin
                if ((s_tbl_q.eps_count != 2'd0) && !r_visited[s_tbl_q.eps_first]) begin
                    n_visited[s_tbl_q.eps_first] = 1'b1;
                    s_wl.push                    = 1'b1;
                    s_wl.push_idx                = s_tbl_q.eps_first;
                end
                n_state = ST_EPS1;
            end
            ST_EPS1: begin
                // count already clamped to two in the table
                if (s_tbl_q.eps_count[1] && !r_visited[s_tbl_q.eps_second]) begin
                    n_visited[s_tbl_q.eps_second] = 1'b1;
                    s_wl.push                     = 1'b1;
                    s_wl.push_idx                 = s_tbl_q.eps_second;
                end
                n_state = ST_Q_RD;
            end
            ST_REPORT: begin
                // wait for a free output register
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_matched = r_visited[r_cfg_accept];
                    n_dead    = ~|r_visited;
                    n_active  = r_visited;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and set registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cfg_start  <= '0;
            r_cfg_accept <= '0;
            r_active     <= '0;
            r_visited    <= '0;
            r_scan       <= '0;
            r_eval_vld   <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cfg_start  <= n_cfg_start;
            r_cfg_accept <= n_cfg_accept;
            r_active     <= n_active;
            r_visited    <= n_visited;
            r_scan       <= n_scan;
            r_eval_vld   <= n_eval_vld;
            r_m_valid    <= n_m_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_eval_idx <= n_eval_idx;
        r_matched  <= n_matched;
        r_dead     <= n_dead;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'd0, r_dead, r_matched};

endmodule

### design/nfarm_table.sv
// ----------------------------------------------------------------------------
// nfarm_table
// Transition table memory: one entry per NFA state, one write port, one
// synchronous read port with registered data that holds between reads.
// ----------------------------------------------------------------------------
module nfarm_table (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [nfarm_pkg::IDX_W-1:0] i_wr_addr,
    input  nfarm_pkg::t_entry          i_wr_entry,
    input  logic                       i_rd_en,
    input  logic [nfarm_pkg::IDX_W-1:0] i_rd_addr,
    output nfarm_pkg::t_entry          o_rd_entry
);

    nfarm_pkg::t_entry r_mem [nfarm_pkg::NUM_STATES];
    nfarm_pkg::t_entry r_rd_entry;
    nfarm_pkg::t_entry s_wr_entry;

    // an epsilon count of three is stored as two
    always_comb begin
        s_wr_entry = i_wr_entry;
        if (i_wr_entry.eps_count == 2'd3) begin
            s_wr_entry.eps_count = 2'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= s_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule

### design/nfarm_worklist.sv
// ----------------------------------------------------------------------------
// nfarm_worklist
// Closure work queue: FIFO of state indexes in a memory. Each state enters at
// most once per closure, so the pointers never wrap between clears.
// ----------------------------------------------------------------------------
module nfarm_worklist (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nfarm_pkg::t_wl_ctrl         i_ctrl,
    output logic                        o_empty,
    output logic [nfarm_pkg::IDX_W-1:0] o_pop_idx
);

    logic [nfarm_pkg::IDX_W-1:0] r_mem [nfarm_pkg::NUM_STATES];
    logic [nfarm_pkg::IDX_W-1:0] r_pop_idx;
    logic [nfarm_pkg::PTR_W-1:0] r_wp, n_wp;
    logic [nfarm_pkg::PTR_W-1:0] r_rp, n_rp;
    logic [nfarm_pkg::PTR_W-1:0] s_wr_ptr;

    // pointer update; a clear with a push lands the push in slot zero
    always_comb begin
        s_wr_ptr = i_ctrl.clear ? '0 : r_wp;
        n_wp     = s_wr_ptr + {{(nfarm_pkg::PTR_W-1){1'b0}}, i_ctrl.push};
        n_rp     = i_ctrl.clear ? '0 : r_rp + {{(nfarm_pkg::PTR_W-1){1'b0}}, i_ctrl.pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    // storage, read data registered
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[s_wr_ptr[nfarm_pkg::IDX_W-1:0]] <= i_ctrl.push_idx;
        end
        if (i_ctrl.pop) begin
            r_pop_idx <= r_mem[r_rp[nfarm_pkg::IDX_W-1:0]];
        end
    end

    assign o_empty   = (r_rp == r_wp);
    assign o_pop_idx = r_pop_idx;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NFA regex matcher. The whole transition table is
// loaded before any start or character request, so no unwritten entry is ever
// read. A short directed part covers the field extremes, the ignored function
// code, clamped epsilon counts, inactive labels and characters before any
// start. Random phases follow, each with fresh registers and a fresh table:
// mostly start requests followed by strings over a small alphabet, plus noise.
// Each accepted request is fed through an in-bench NFA model and every result
// is compared with the oldest prediction. Both sides idle at random, and the
// result side is held off once for a long stretch to back up the request side.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          NS            = nfarm_pkg::NUM_STATES;
    localparam int          IW            = nfarm_pkg::IDX_W;
    localparam int          CLK_HALF_NS   = 10;
    localparam int          RESET_CYCLES  = 11;
    localparam int          SETTLE_CYCLES = 400;        // above the worst request latency
    localparam int          HOLD_CYCLES   = 2000;
    localparam int          TIMEOUT_NS    = 50_000_000; // several times the slowest run
    localparam int          RAND_PHASES   = 5;
    localparam int          PHASE_ITEMS   = 140;
    localparam logic [1:0]  FN_SPARE      = 2'd3;       // unused code, dropped by the block
    localparam logic [7:0]  CH_A          = 8'h61;
    localparam logic [7:0]  CH_B          = 8'h62;
    localparam logic [7:0]  CH_C          = 8'h63;
    localparam logic [7:0]  CH_Z          = 8'h7a;

    // one request as the bench sees it
    typedef struct packed {
        logic [1:0]    func;
        logic [IW-1:0] idx;
        logic [7:0]    label;
        logic          has_label;
        logic [IW-1:0] target;
        logic [1:0]    eps_cnt;
        logic [IW-1:0] eps0;
        logic [IW-1:0] eps1;
        logic [7:0]    chr;
    } t_req_item;

    typedef struct packed {
        logic matched;
        logic dead;
    } t_verdict;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [5:0]  cfg_wdata = '0;

    // request feed and result expectations
    t_req_item   req_queue[$];
    t_req_item   req_cur;
    t_verdict    verdict_q[$];
    bit          req_accepted = 1'b0;
    bit          res_taken = 1'b0;
    bit          fast_send = 1'b0;
    bit          fast_recv = 1'b0;
    int unsigned send_gap = 0;
    int unsigned recv_wait = 0;
    int unsigned hold_cnt = 0;

    // NFA model state
    nfarm_pkg::t_entry nfa_tbl [NS];
    logic [NS-1:0]     live_set = '0;
    logic [IW-1:0]     nfa_start = '0;
    logic [IW-1:0]     nfa_accept = '0;

    int unsigned n_req = 0, n_writes = 0, n_results = 0, n_matched = 0;
    int unsigned n_dead = 0, n_cfg = 0, n_err = 0;

    nfa_regex_matcher_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // NFA model
    // ------------------------------------------------------------------------

    // states reachable over epsilon edges; each sweep adds a state or settles
    function automatic logic [NS-1:0] eps_closure(input logic [NS-1:0] seed);
        logic [NS-1:0] reach;
        int unsigned   n_eps;
        reach = seed;
        for (int sweep = 0; sweep < NS; sweep++) begin
            for (int s = 0; s < NS; s++) begin
                if (reach[s]) begin
                    n_eps = (nfa_tbl[s].eps_count > 2'd2) ? 2 : nfa_tbl[s].eps_count;
                    if (n_eps > 0) reach[nfa_tbl[s].eps_first] = 1'b1;
                    if (n_eps > 1) reach[nfa_tbl[s].eps_second] = 1'b1;
                end
            end
        end
        return reach;
    endfunction

    // apply one accepted request and queue the verdict it should produce
    function automatic void advance_nfa(input t_req_item r);
        logic [NS-1:0] moved;
        t_verdict      v;
        moved = '0;
        case (r.func)
            nfarm_pkg::FN_WRITE: begin
                nfa_tbl[r.idx] = '{eps_second: r.eps1, eps_first: r.eps0,
                                   eps_count: r.eps_cnt, label_target: r.target,
                                   has_label: r.has_label, label: r.label};
                n_writes++;
            end
            nfarm_pkg::FN_START: begin
                moved[nfa_start] = 1'b1;
                live_set = eps_closure(moved);
            end
            nfarm_pkg::FN_CHAR: begin
                for (int s = 0; s < NS; s++) begin
                    if (live_set[s] && nfa_tbl[s].has_label && nfa_tbl[s].label == r.chr)
                        moved[nfa_tbl[s].label_target] = 1'b1;
                end
                live_set = eps_closure(moved);
            end
            default: ;
        endcase
        if (r.func == nfarm_pkg::FN_START || r.func == nfarm_pkg::FN_CHAR) begin
            v.matched = live_set[nfa_accept];
            v.dead    = (live_set == '0);
            verdict_q.insert(verdict_q.size(), v);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------------

    // append one request to the pending feed
    function automatic void queue_req(input t_req_item r);
        req_queue.insert(req_queue.size(), r);
    endfunction

    // every field random, so that unused fields toggle too
    function automatic t_req_item scrambled_req(input logic [1:0] fn);
        t_req_item r;
        r.func      = fn;
        r.idx       = IW'($urandom);
        r.label     = 8'($urandom);
        r.has_label = 1'($urandom);
        r.target    = IW'($urandom);
        r.eps_cnt   = 2'($urandom);
        r.eps0      = IW'($urandom);
        r.eps1      = IW'($urandom);
        r.chr       = 8'($urandom);
        return r;
    endfunction

    function automatic t_req_item make_write(input int unsigned idx, input logic has,
                                             input logic [7:0] label, input int unsigned target,
                                             input logic [1:0] cnt, input int unsigned e0,
                                             input int unsigned e1);
        t_req_item r;
        r           = scrambled_req(nfarm_pkg::FN_WRITE);
        r.idx       = IW'(idx);
        r.has_label = has;
        r.label     = label;
        r.target    = IW'(target);
        r.eps_cnt   = cnt;
        r.eps0      = IW'(e0);
        r.eps1      = IW'(e1);
        return r;
    endfunction

    // mostly short forward edges over a three-letter alphabet, so sets live on
    function automatic t_req_item random_entry(input int unsigned s);
        t_req_item   r;
        int unsigned pick;
        r           = scrambled_req(nfarm_pkg::FN_WRITE);
        r.idx       = IW'(s);
        r.has_label = ($urandom_range(0, 9) < 7);
        if ($urandom_range(0, 9) != 0) r.label = CH_A + 8'($urandom_range(0, 2));
        if ($urandom_range(0, 7) != 0) r.target = IW'(s + $urandom_range(1, 3));
        pick = $urandom_range(0, 19);
        r.eps_cnt = (pick < 10) ? 2'd0 : (pick < 16) ? 2'd1 : (pick < 19) ? 2'd2 : 2'd3;
        if ($urandom_range(0, 7) != 0) begin
            r.eps0 = IW'(s + $urandom_range(0, 4));
            r.eps1 = IW'(s + $urandom_range(1, 5));
        end
        return r;
    endfunction

    function automatic t_req_item char_req(input logic [7:0] c);
        t_req_item r;
        r     = scrambled_req(nfarm_pkg::FN_CHAR);
        r.chr = c;
        return r;
    endfunction

    // strings from a start request, table rewrites, lone bytes, ignored codes
    task automatic queue_random_traffic(input int unsigned quota);
        int unsigned n_items;
        int unsigned pick;
        int unsigned len;
        t_req_item   r;
        n_items = 0;
        while (n_items < quota) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
                queue_req(scrambled_req(nfarm_pkg::FN_START));
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    r = scrambled_req(nfarm_pkg::FN_CHAR);
                    if ($urandom_range(0, 9) != 0) r.chr = CH_A + 8'($urandom_range(0, 2));
                    queue_req(r);
                end
                n_items += len + 1;
            end else if (pick < 17) begin
                queue_req(random_entry($urandom_range(0, NS - 1)));
                n_items++;
            end else if (pick < 18) begin
                queue_req(scrambled_req(FN_SPARE));
            end else begin
                queue_req(scrambled_req(nfarm_pkg::FN_CHAR));
                n_items++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Phase control
    // ------------------------------------------------------------------------

    task automatic write_reg(input logic idx, input logic [5:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == nfarm_pkg::CFG_START) nfa_start = val;
        else nfa_accept = val;
        n_cfg++;
    endtask

    // all requests in, all results out, then let trailing writes finish
    task automatic drain_and_settle();
        while (req_queue.size() > 0 || s_valid || verdict_q.size() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------------
    initial begin
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[nfa_regex_matcher_top] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // offer the next queued request after a random gap
    always @(negedge clk) begin : req_driver
        logic valid_next;
        valid_next = s_valid;
        if (req_accepted) begin
            req_accepted = 1'b0;
            valid_next   = 1'b0;
            send_gap     = fast_send ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 39) == 0) fast_send = !fast_send;
        end
        if (rst_n && !valid_next) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (req_queue.size() > 0) begin
                req_cur    = req_queue.pop_front();
                s_tuser   <= req_cur.func;
                s_tdata   <= {5'd0, req_cur.chr, req_cur.eps1, req_cur.eps0, req_cur.eps_cnt,
                              req_cur.target, req_cur.has_label, req_cur.label, req_cur.idx};
                valid_next = 1'b1;
            end
        end
        s_valid <= valid_next;
    end

    always @(posedge clk) begin : req_accept
        if (rst_n && s_valid && s_tready) begin
            req_accepted = 1'b1;
            n_req++;
            advance_nfa(req_cur);
        end
    end

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // long hold-off, counted down on its own
    always @(posedge clk) begin : rx_hold
        if (hold_cnt > 0) hold_cnt--;
    end

    always @(negedge clk) begin : res_ready
        if (res_taken) begin
            res_taken = 1'b0;
            recv_wait = fast_recv ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 39) == 0) fast_recv = !fast_recv;
        end
        if (!rst_n || hold_cnt > 0) begin
            m_ready <= 1'b0;
        end else if (recv_wait > 0) begin
            recv_wait--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each result with the oldest prediction
    always @(posedge clk) begin : res_check
        t_verdict want;
        if (rst_n && m_tvalid && m_ready) begin
            res_taken = 1'b1;
            n_results++;
            if (m_tdata[0]) n_matched++;
            if (m_tdata[1]) n_dead++;
            if (verdict_q.size() == 0) begin
                n_err++;
                $display("%0t: result with none expected, actual matched=%0b dead=%0b",
                         $time, m_tdata[0], m_tdata[1]);
            end else begin
                want = verdict_q.pop_front();
                if (m_tdata[0] !== want.matched) begin
                    n_err++;
                    $display("%0t: matched mismatch, expected %0b actual %0b",
                             $time, want.matched, m_tdata[0]);
                end
                if (m_tdata[1] !== want.dead) begin
                    n_err++;
                    $display("%0t: dead mismatch, expected %0b actual %0b",
                             $time, want.dead, m_tdata[1]);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_req_item r;
        while (!rst_n) @(posedge clk);
        @(posedge clk);

        // full table first: a small hand-built NFA, every other state inert
        for (int s = 0; s < NS; s++) begin
            case (s)
                0:  r = make_write(s, 1'b0, 8'($urandom), 0, 2'd2, 1, 6);
                1:  r = make_write(s, 1'b1, CH_A, 2, 2'd0, 0, 0);
                2:  r = make_write(s, 1'b0, 8'h00, 0, 2'd3, 3, 5);   // count clamps to two
                3:  r = make_write(s, 1'b1, CH_B, 2, 2'd0, 63, 63);
                5:  r = make_write(s, 1'b1, 8'hff, 62, 2'd0, 0, 0);
                6:  r = make_write(s, 1'b0, CH_B, 62, 2'd1, 7, 62);  // label off, only the first epsilon edge used
                7:  r = make_write(s, 1'b1, 8'h00, 63, 2'd0, 0, 0);
                63: r = make_write(s, 1'b1, CH_Z, 0, 2'd2, 62, 63);
                default: begin
                    r           = scrambled_req(nfarm_pkg::FN_WRITE);
                    r.idx       = IW'(s);
                    r.has_label = 1'b0;
                    r.eps_cnt   = 2'd0;
                end
            endcase
            queue_req(r);
        end
        // reset registers: a byte before any start, then a start that accepts state 0
        queue_req(char_req(CH_A));
        queue_req(scrambled_req(nfarm_pkg::FN_START));
        queue_req(char_req(CH_A));
        drain_and_settle();

        write_reg(nfarm_pkg::CFG_START, 6'd0);
        write_reg(nfarm_pkg::CFG_ACCEPT, 6'd62);
        @(posedge clk);
        queue_req(scrambled_req(nfarm_pkg::FN_START));
        queue_req(char_req(CH_A));
        queue_req(char_req(CH_B));
        queue_req(char_req(8'hff));
        queue_req(char_req(CH_A));      // set empties
        queue_req(char_req(CH_A));      // and stays empty
        queue_req(scrambled_req(nfarm_pkg::FN_START));
        queue_req(char_req(8'h00));
        queue_req(char_req(CH_Z));
        queue_req(char_req(CH_B));      // only an unlabelled state carries b
        queue_req(scrambled_req(FN_SPARE));
        queue_req(scrambled_req(nfarm_pkg::FN_START));
        queue_req(char_req(CH_C));
        drain_and_settle();

        write_reg(nfarm_pkg::CFG_START, 6'd63);
        write_reg(nfarm_pkg::CFG_ACCEPT, 6'd63);
        @(posedge clk);
        queue_req(scrambled_req(nfarm_pkg::FN_START));
        queue_req(char_req(CH_Z));
        queue_req(make_write(63, 1'b1, 8'hff, 63, 2'd0, 0, 0));
        queue_req(scrambled_req(nfarm_pkg::FN_START));
        queue_req(char_req(8'hff));
        queue_req(char_req(8'hff));
        queue_req(char_req(8'h00));

        // random phases, each with new registers and a new table
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_and_settle();
            write_reg(nfarm_pkg::CFG_START, 6'($urandom));
            write_reg(nfarm_pkg::CFG_ACCEPT, 6'($urandom));
            if (ph == 0) hold_cnt = HOLD_CYCLES;  // back up the request side
            @(posedge clk);
            for (int s = 0; s < NS; s++) queue_req(random_entry(s));
            queue_random_traffic(PHASE_ITEMS);
        end
        drain_and_settle();

        $display("Run covered %0d requests (%0d table writes) and %0d results, %0d matched, %0d dead",
                 n_req, n_writes, n_results, n_matched, n_dead);
        $display("Register writes: %0d over %0d random phases, %0d mismatches",
                 n_cfg, RAND_PHASES, n_err);
        if (n_err == 0) begin
            $display("[nfa_regex_matcher_top] OK");
        end else begin
            $display("[nfa_regex_matcher_top] ERROR");
        end
        $finish;
    end

endmodule
